FILE: hw/rtl/pdc_pkg.sv
// Shared widths, constants and types for the PWM period and duty capture block.
`timescale 1ns / 1ps
`default_nettype none
package pdc_pkg;

	// timer count width
	localparam int COUNT_WIDTH = 16;
	localparam int TOTAL_W     = COUNT_WIDTH + 1;
	localparam int DUTY_W      = 7;
	// on_time * 100 fits below 2^(COUNT_WIDTH + DUTY_W)
	localparam int NUM_W       = COUNT_WIDTH + DUTY_W;

	// 100 = 2^6 + 2^5 + 2^2
	localparam int PCT_SHIFT_A = 6;
	localparam int PCT_SHIFT_B = 5;
	localparam int PCT_SHIFT_C = 2;

	localparam int SER_CNT_W = $clog2(COUNT_WIDTH);
	localparam int DIV_CNT_W = $clog2(DUTY_W);

	localparam int IN_TDATA_W   = ((COUNT_WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS     = 2 * COUNT_WIDTH + TOTAL_W + DUTY_W;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_TUSER_W  = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SERIAL,
		ST_DIVIDE,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic                   done;
		logic [COUNT_WIDTH-1:0] elapsed;
		logic [TOTAL_W-1:0]     total;
	} ser_res_t;

	typedef struct packed {
		logic              done;
		logic              zero;
		logic [DUTY_W-1:0] duty;
	} div_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pdc_serial_alu.sv
// Bit-serial subtract and add: elapsed time and period, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pdc_serial_alu (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [pdc_pkg::COUNT_WIDTH-1:0] now,
	input  wire logic [pdc_pkg::COUNT_WIDTH-1:0] last,
	input  wire logic [pdc_pkg::COUNT_WIDTH-1:0] other,
	output pdc_pkg::ser_res_t                    res
);
	import pdc_pkg::*;

	logic [COUNT_WIDTH-1:0] a_q, b_q, c_q, e_q, t_q;
	logic                   borrow_q, carry_q;
	logic [SER_CNT_W-1:0]   cnt_q;
	logic                   busy_q, done_q;
	logic                   ai, bi, ci, d, nb, s, nc;

	// elapsed bit from now - last, then period bit from other + elapsed
	always_comb begin
		ai = a_q[0];
		bi = b_q[0];
		ci = c_q[0];
		d  = ai ^ bi ^ borrow_q;
		nb = (~ai & bi) | (~(ai ^ bi) & borrow_q);
		s  = ci ^ d ^ carry_q;
		nc = (ci & d) | (ci & carry_q) | (d & carry_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SER_CNT_W'(COUNT_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= now;
			b_q      <= last;
			c_q      <= other;
			borrow_q <= 1'b0;
			carry_q  <= 1'b0;
		end else if (busy_q) begin
			a_q      <= a_q >> 1;
			b_q      <= b_q >> 1;
			c_q      <= c_q >> 1;
			e_q      <= {d, e_q[COUNT_WIDTH-1:1]};
			t_q      <= {s, t_q[COUNT_WIDTH-1:1]};
			borrow_q <= nb;
			carry_q  <= nc;
		end
	end

	assign res.done    = done_q;
	assign res.elapsed = e_q;
	assign res.total   = {carry_q, t_q};

endmodule
`default_nettype wire

FILE: hw/rtl/pdc_divider.sv
// Scale by 100 with shift-adds, then restoring division one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pdc_divider (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [pdc_pkg::COUNT_WIDTH-1:0] on_time,
	input  wire logic [pdc_pkg::TOTAL_W-1:0]     total,
	output pdc_pkg::div_res_t                    res
);
	import pdc_pkg::*;

	logic [NUM_W-1:0]       rem_q, dsh_q;
	logic [COUNT_WIDTH-1:0] on_q;
	logic [DUTY_W-1:0]      q_q;
	logic                   zero_q;
	logic                   busy_q, scale_q, done_q;
	logic [DIV_CNT_W-1:0]   step_q;
	logic                   ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			scale_q <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				if (total == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q  <= 1'b1;
					scale_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (scale_q) begin
					scale_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_CNT_W'(DUTY_W - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (total == '0);
			q_q    <= '0;
			on_q   <= on_time;
			rem_q  <= (NUM_W'(on_time) << PCT_SHIFT_A) + (NUM_W'(on_time) << PCT_SHIFT_B);
			dsh_q  <= NUM_W'(total) << (DUTY_W - 1);
		end else if (busy_q) begin
			if (scale_q) begin
				rem_q <= rem_q + (NUM_W'(on_q) << PCT_SHIFT_C);
			end else begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				q_q   <= {q_q[DUTY_W-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
		end
	end

	assign res.done = done_q;
	assign res.zero = zero_q;
	assign res.duty = q_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pwm_period_duty_capture.sv
// Top level of the PWM period and duty capture block.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata: capture_time
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata: off, on, total, duty
//                                               tuser: edge_kind, zero_period
//
// One request is in work at a time; the next request is taken once the
// result of the last one is loaded into the output register. The divide is
// skipped when the period is zero.
// The pace is set by the bit-serial subtract/add pass (one bit a cycle over
// the count) and by the restoring divider (a scaling step, then one duty
// bit a cycle).
// Reset clears the edge phase, the last capture and both stored times to 0.
// A result waits in the output register while the next request is taken;
// a stalled output holds the pipeline only at the final load.
`timescale 1ns / 1ps
`default_nettype none
module pwm_period_duty_capture (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [15:0] capture_time, rest ignored
	input  wire logic [pdc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [15:0] off_time, [31:16] on_time, [48:32] total_period, [55:49] duty_percent
	output logic [pdc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// [0] edge_kind, [1] zero_period
	output logic [pdc_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
	import pdc_pkg::*;

	state_t state_q, state_d;

	logic                   expect_falling_q;
	logic [COUNT_WIDTH-1:0] last_capture_q, off_q, on_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   edge_q;

	logic                   accept, div_start, out_load;
	logic [COUNT_WIDTH-1:0] now, other, new_on;
	ser_res_t               ser;
	div_res_t               div;

	logic                   m_valid_q;
	logic [COUNT_WIDTH-1:0] off_out_q, on_out_q;
	logic [TOTAL_W-1:0]     total_out_q;
	logic [DUTY_W-1:0]      duty_out_q;
	logic                   edge_out_q, zero_out_q;

	assign now    = s_axis_tdata[COUNT_WIDTH-1:0];
	// the store that this edge does not replace feeds the period sum
	assign other  = expect_falling_q ? off_q : on_q;
	assign new_on = expect_falling_q ? ser.elapsed : on_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_SERIAL;
			ST_SERIAL: if (ser.done) state_d = ST_DIVIDE;
			ST_DIVIDE: if (div.done) state_d = ST_OUTPUT;
			ST_OUTPUT: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_SERIAL: div_start = ser.done;
			ST_OUTPUT: out_load = !m_valid_q || m_axis_tready;
			default:   s_axis_tready = 1'b0;
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	pdc_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.now    (now),
		.last   (last_capture_q),
		.other  (other),
		.res    (ser)
	);

	pdc_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.on_time (new_on),
		.total   (ser.total),
		.res     (div)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			expect_falling_q <= 1'b0;
			last_capture_q   <= '0;
			off_q            <= '0;
			on_q             <= '0;
			m_valid_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			// old capture goes to the serial unit at this same edge
			if (accept) begin
				last_capture_q <= now;
			end
			// commit the measured time and flip the edge phase
			if (div_start) begin
				if (expect_falling_q) begin
					on_q <= ser.elapsed;
				end else begin
					off_q <= ser.elapsed;
				end
				expect_falling_q <= !expect_falling_q;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// hold period and edge kind while the divider runs, then load the output register
	always_ff @(posedge clk) begin
		if (div_start) begin
			total_q <= ser.total;
			edge_q  <= expect_falling_q;
		end
		if (out_load) begin
			off_out_q   <= off_q;
			on_out_q    <= on_q;
			total_out_q <= total_q;
			duty_out_q  <= div.duty;
			edge_out_q  <= edge_q;
			zero_out_q  <= div.zero;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({duty_out_q, total_out_q, on_out_q, off_out_q});
	assign m_axis_tuser  = {zero_out_q, edge_out_q};

	// one request at a time: the port closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("request accepted while another is in work");

	// serial unit finishes only while the controller waits for it
	a_ser_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		ser.done |-> (state_q == ST_SERIAL))
		else $error("serial pass finished outside its phase");

	// divider finishes only while the controller waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div.done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside its phase");

	// period is the sum of the reported times; a zero period reports zero duty
	a_out_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (total_out_q == TOTAL_W'(off_out_q) + TOTAL_W'(on_out_q))
			&& (!zero_out_q || duty_out_q == '0))
		else $error("result fields inconsistent");

endmodule
`default_nettype wire

FILE: verif/pdc_checker.sv
// Checker for the PWM period and duty capture block: predicts each measurement and compares it.
`timescale 1ns / 1ps
`default_nettype none
module pdc_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	input  wire logic                               s_axis_tready,
	input  wire logic [pdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire logic                               m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	input  wire logic [pdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  wire logic [pdc_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
	output int                                      fail_count,
	output int                                      open_count
);
	import pdc_pkg::*;

	localparam int CW        = COUNT_WIDTH;
	localparam int ON_LSB    = CW;
	localparam int TOTAL_LSB = 2 * CW;
	localparam int DUTY_LSB  = 2 * CW + TOTAL_W;

	localparam logic EDGE_RISING  = 1'b0;
	localparam logic EDGE_FALLING = 1'b1;

	localparam int unsigned PERCENT_SCALE = 100;

	typedef struct packed {
		logic               edge_kind;
		logic [CW-1:0]      off_ticks;
		logic [CW-1:0]      on_ticks;
		logic [TOTAL_W-1:0] period_ticks;
		logic [DUTY_W-1:0]  duty_pct;
		logic               zero_period;
	} pwm_meas_t;

	// measurement state as the block should hold it
	logic          awaiting_fall;
	logic [CW-1:0] prev_capture;
	logic [CW-1:0] low_ticks;
	logic [CW-1:0] high_ticks;

	pwm_meas_t pending_meas[$];

	// update the stored times from one edge and queue the measurement it gives
	task automatic measure_edge(input logic [CW-1:0] capture);
		logic [CW-1:0] elapsed;
		int unsigned   scaled;
		pwm_meas_t     meas;
		elapsed = capture - prev_capture;
		if (!awaiting_fall) begin
			low_ticks      = elapsed;
			meas.edge_kind = EDGE_RISING;
		end else begin
			high_ticks     = elapsed;
			meas.edge_kind = EDGE_FALLING;
		end
		awaiting_fall     = !awaiting_fall;
		prev_capture      = capture;
		meas.off_ticks    = low_ticks;
		meas.on_ticks     = high_ticks;
		meas.period_ticks = TOTAL_W'(low_ticks) + TOTAL_W'(high_ticks);
		if (meas.period_ticks == '0) begin
			meas.zero_period = 1'b1;
			meas.duty_pct    = '0;
		end else begin
			scaled           = int'(high_ticks) * PERCENT_SCALE;
			meas.zero_period = 1'b0;
			meas.duty_pct    = DUTY_W'(scaled / int'(meas.period_ticks));
		end
		pending_meas.push_back(meas);
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pwm_meas_t want;
		if (!arst_n) begin
			awaiting_fall = 1'b0;
			prev_capture  = '0;
			low_ticks     = '0;
			high_ticks    = '0;
			pending_meas.delete();
		end else begin
			// retire the result first: it can only belong to an earlier request
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_meas.size() == 0) begin
					$display("%0t: unexpected result, expected none, got tdata %h tuser %b",
						$time, m_axis_tdata, m_axis_tuser);
					fail_count++;
				end else begin
					want = pending_meas.pop_front();
					check_field("edge_kind", want.edge_kind, m_axis_tuser[0]);
					check_field("off_time", want.off_ticks, m_axis_tdata[0 +: CW]);
					check_field("on_time", want.on_ticks, m_axis_tdata[ON_LSB +: CW]);
					check_field("total_period", want.period_ticks,
						m_axis_tdata[TOTAL_LSB +: TOTAL_W]);
					check_field("duty_percent", want.duty_pct,
						m_axis_tdata[DUTY_LSB +: DUTY_W]);
					check_field("zero_period", want.zero_period, m_axis_tuser[1]);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				measure_edge(s_axis_tdata[CW-1:0]);
		end
		open_count = pending_meas.size();
	end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Top of the testbench: drives edge captures into the block and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import pdc_pkg::*;

	localparam int CW          = COUNT_WIDTH;
	localparam int RANDOM_CAPS = 630;
	localparam int TAIL_CAPS   = 80;

	// edge sequence for the corner cases: zero period, full duty, zero duty,
	// timer wrap, largest period, rounding and alternating bit patterns
	localparam logic [CW-1:0] DIRECTED_CAPS [20] = '{
		16'h0000, 16'h0000, 16'h0000, 16'd100, 16'd100, 16'd300, 16'd1000, 16'd1000,
		16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFE, 16'h0000, 16'h0001, 16'h0002, 16'h0004,
		16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	int                     fail_count;
	int                     open_count;

	logic                   tail_phase;
	int                     gap_odds;
	logic [CW-1:0]          last_sent;
	int                     ready_run;

	pwm_period_duty_capture u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	pdc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.fail_count   (fail_count),
		.open_count   (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// offer one capture, optionally after an idle burst, and hold it until taken
	task automatic send_capture(input logic [CW-1:0] capture);
		if (!tail_phase && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= IN_TDATA_W'($urandom);
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'(capture);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		last_sent = capture;
	endtask

	// pick the next capture: mostly a plausible PWM edge, some noise and extremes
	function automatic logic [CW-1:0] next_capture(input logic [CW-1:0] prev);
		logic [CW-1:0] capture;
		case ($urandom_range(0, 9))
			0, 1:    capture = CW'($urandom);
			2, 3:    capture = prev + CW'($urandom_range(1, 20));
			4, 5:    capture = prev + CW'($urandom_range(21, 2000));
			6:       capture = prev + CW'($urandom_range(2001, 65535));
			7:       capture = prev;
			8:       capture = prev - CW'($urandom_range(1, 20));
			default: begin
				case ($urandom_range(0, 3))
					0:       capture = '0;
					1:       capture = '1;
					2:       capture = 16'hAAAA;
					default: capture = 16'h5555;
				endcase
			end
		endcase
		return capture;
	endfunction

	// receiver: ready and stall bursts, long ready stretches, always ready at the tail
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (tail_phase) begin
				m_axis_tready <= 1'b1;
			end else begin
				case ($urandom_range(0, 5))
					0, 1, 2: begin
						m_axis_tready <= 1'b1;
						ready_run = $urandom_range(1, 16);
					end
					3, 4: begin
						m_axis_tready <= 1'b0;
						ready_run = $urandom_range(1, 16);
					end
					default: begin
						m_axis_tready <= 1'b1;
						ready_run = $urandom_range(40, 200);
					end
				endcase
				repeat (ready_run - 1) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		tail_phase    = 1'b0;
		gap_odds      = 3;
		last_sent     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_CAPS[i])
			send_capture(DIRECTED_CAPS[i]);

		for (int i = 0; i < RANDOM_CAPS; i++) begin
			// change the sender's idle pattern every 40 captures
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       gap_odds = 0;
					1:       gap_odds = 2;
					default: gap_odds = 5;
				endcase
			end
			if (i == RANDOM_CAPS - TAIL_CAPS)
				tail_phase = 1'b1;
			send_capture(next_capture(last_sent));
		end
		s_axis_tvalid <= 1'b0;

		// drain: wait for every measurement, then let the block settle
		wait (open_count == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
